// ===== rtl/per_flow_time_bin_aggregator_macros.svh =====
// assertion macros for the per-flow time-bin aggregator
`ifndef PER_FLOW_TIME_BIN_AGGREGATOR_MACROS_SVH
`define PER_FLOW_TIME_BIN_AGGREGATOR_MACROS_SVH
`ifndef SYNTHESIS
`define PFTBA_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("pftba assertion failed");
`define PFTBA_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("pftba assertion failed");
`else
`define PFTBA_ASSERT_SAME(label, clk, rstn, ante, cons)
`define PFTBA_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

// ===== rtl/pftba_pkg.sv =====
// shared types and constants of the per-flow time-bin aggregator
`timescale 1ns / 1ps
package pftba_pkg;

    localparam logic SIDE_LAT = 1'b0;
    localparam logic SIDE_PRE = 1'b1;

    localparam logic CFG_WINDOW_IDX = 1'b0;
    localparam logic CFG_MINEV_IDX  = 1'b1;

    localparam logic [31:0] WINDOW_RESET = 32'd200000000;
    localparam logic [31:0] MINEV_RESET  = 32'd1000;

    typedef struct packed {
        logic        vld;
        logic        side;
        logic        done;
        logic        closed;
        logic        visible;
        logic [63:0] key;
        logic [63:0] time_ns;
        logic [63:0] lat_ns;
        logic [63:0] cstart;
        logic [63:0] ctotal;
        logic [31:0] ccount;
    } tok_t;

    function automatic tok_t make_tok(input logic side, input logic [63:0] key,
                                      input logic [63:0] time_ns,
                                      input logic [63:0] lat_ns);
        tok_t t;
        t         = '0;
        t.vld     = 1'b1;
        t.side    = side;
        t.key     = key;
        t.time_ns = time_ns;
        t.lat_ns  = lat_ns;
        return t;
    endfunction

endpackage

// ===== rtl/pftba_cell.sv =====
// one flow slot of the lookup chain: id, open bins and event count
`timescale 1ns / 1ps
module pftba_cell (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [31:0]       window_ns,
    input  logic [31:0]       min_events_visible,
    input  pftba_pkg::tok_t   tok_in,
    output pftba_pkg::tok_t   tok_out
);
    import pftba_pkg::*;

    logic        used_reg, used_next;
    logic [63:0] id_reg, id_next;
    logic        lat_open_reg, lat_open_next;
    logic [63:0] lat_start_reg, lat_start_next;
    logic [63:0] lat_sum_reg, lat_sum_next;
    logic [31:0] lat_cnt_reg, lat_cnt_next;
    logic        pre_open_reg, pre_open_next;
    logic [63:0] pre_start_reg, pre_start_next;
    logic [31:0] pre_cnt_reg, pre_cnt_next;
    logic [31:0] events_reg, events_next;
    tok_t        tok_reg, tok_next;

    logic        hit, grab;
    logic        lat_open_eff, pre_open_eff;
    logic [31:0] events_eff;
    logic [63:0] lat_diff, pre_diff;
    logic        lat_in, pre_in;
    logic [64:0] sum_wide;

    always_comb begin
        hit          = tok_in.vld && !tok_in.done && used_reg && (id_reg == tok_in.key);
        grab         = tok_in.vld && !tok_in.done && !used_reg;
        lat_open_eff = used_reg && lat_open_reg;
        pre_open_eff = used_reg && pre_open_reg;
        events_eff   = grab ? 32'd0 : events_reg;
        lat_diff     = tok_in.time_ns - lat_start_reg;
        pre_diff     = tok_in.time_ns - pre_start_reg;
        lat_in       = lat_diff < {32'd0, window_ns};
        pre_in       = pre_diff < {32'd0, window_ns};
        sum_wide     = {1'b0, lat_sum_reg} + {1'b0, tok_in.lat_ns};

        used_next      = used_reg;
        id_next        = id_reg;
        lat_open_next  = lat_open_reg;
        lat_start_next = lat_start_reg;
        lat_sum_next   = lat_sum_reg;
        lat_cnt_next   = lat_cnt_reg;
        pre_open_next  = pre_open_reg;
        pre_start_next = pre_start_reg;
        pre_cnt_next   = pre_cnt_reg;
        events_next    = events_reg;
        tok_next       = tok_in;

        if (hit || grab) begin
            used_next     = 1'b1;
            id_next       = tok_in.key;
            tok_next.done = 1'b1;
            if (grab) begin
                lat_open_next = 1'b0;
                pre_open_next = 1'b0;
            end
            if (tok_in.side == SIDE_LAT) begin
                if (lat_open_eff && lat_in) begin
                    lat_sum_next = sum_wide[64] ? '1 : sum_wide[63:0];
                    lat_cnt_next = (lat_cnt_reg == '1) ? lat_cnt_reg : lat_cnt_reg + 32'd1;
                end else begin
                    if (lat_open_eff) begin
                        tok_next.closed = 1'b1;
                        tok_next.cstart = lat_start_reg;
                        tok_next.ctotal = lat_sum_reg;
                        tok_next.ccount = lat_cnt_reg;
                    end
                    lat_open_next  = 1'b1;
                    lat_start_next = tok_in.time_ns;
                    lat_sum_next   = tok_in.lat_ns;
                    lat_cnt_next   = 32'd1;
                end
                events_next      = (events_eff == '1) ? events_eff : events_eff + 32'd1;
                tok_next.visible = events_next >= min_events_visible;
            end else begin
                if (pre_open_eff && pre_in) begin
                    pre_cnt_next = (pre_cnt_reg == '1) ? pre_cnt_reg : pre_cnt_reg + 32'd1;
                end else begin
                    if (pre_open_eff) begin
                        tok_next.closed = 1'b1;
                        tok_next.cstart = pre_start_reg;
                        tok_next.ccount = pre_cnt_reg;
                    end
                    pre_open_next  = 1'b1;
                    pre_start_next = tok_in.time_ns;
                    pre_cnt_next   = 32'd1;
                end
                events_next      = events_eff;
                tok_next.visible = events_eff >= min_events_visible;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg     <= 1'b0;
            lat_open_reg <= 1'b0;
            pre_open_reg <= 1'b0;
            tok_reg.vld  <= 1'b0;
        end else begin
            used_reg     <= used_next;
            lat_open_reg <= lat_open_next;
            pre_open_reg <= pre_open_next;
            tok_reg      <= tok_next;
        end
        id_reg        <= id_next;
        lat_start_reg <= lat_start_next;
        lat_sum_reg   <= lat_sum_next;
        lat_cnt_reg   <= lat_cnt_next;
        pre_start_reg <= pre_start_next;
        pre_cnt_reg   <= pre_cnt_next;
        events_reg    <= events_next;
    end

    assign tok_out = tok_reg;

endmodule

// ===== rtl/pftba_div.sv =====
// restoring divider, 64-bit dividend by 32-bit divisor, one bit per cycle
`timescale 1ns / 1ps
module pftba_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [31:0] divisor,
    output logic        busy,
    output logic        done,
    output logic [63:0] quotient
);
    logic [63:0] quo_reg, quo_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] den_reg;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] trial;
    logic [32:0] diff;

    always_comb begin
        trial     = {rem_reg, quo_reg[63]};
        diff      = trial - {1'b0, den_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (busy_reg) begin
            if (!diff[32]) begin
                rem_next = diff[31:0];
                quo_next = {quo_reg[62:0], 1'b1};
            end else begin
                rem_next = trial[31:0];
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= 7'd64;
            quo_reg  <= dividend;
            rem_reg  <= '0;
            den_reg  <= divisor;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            quo_reg  <= quo_next;
            rem_reg  <= rem_next;
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/per_flow_time_bin_aggregator.sv =====
// top level of the per-flow time-bin aggregator
//
// s_ channel: one scheduling event per beat (timestamp, running and
// preempted flow ids, latency). m_ channel: two beats per event, first the
// latency side of the running flow, then the preemption side of the
// preempted flow (m_last high on the second).
// APB port: register 0 window_ns at 0x0, register 1 min_events_visible at 0x4.
// Flow slots form a chain of FLOW_SLOTS cells; a lookup token steps one cell
// per cycle, the preemption token in the cycle after the latency token.
// When the latency side closes a bin, the result waits for the bit-serial
// average divide. One event is in flight at a time.
// Reset empties the flow table and clears the running peaks; registers go
// back to 200000000 and 1000. A stalled receiver holds the result beat and
// s_ready stays low until both beats are taken.
`timescale 1ns / 1ps
`include "per_flow_time_bin_aggregator_macros.svh"
module per_flow_time_bin_aggregator #(
    parameter int FLOW_SLOTS = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_event_time_ns,
    input  logic [63:0] s_running_flow,
    input  logic [63:0] s_preempted_flow,
    input  logic [63:0] s_sample_latency_ns,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_side,
    output logic        m_bin_closed,
    output logic [63:0] m_flow_key,
    output logic [63:0] m_closed_start_ns,
    output logic [63:0] m_closed_total_ns,
    output logic [31:0] m_closed_count,
    output logic        m_visible,
    output logic        m_table_full,
    output logic [63:0] m_peak_avg_latency_ns,
    output logic [31:0] m_peak_preemptions,
    output logic [63:0] m_latest_closed_ns,
    output logic        m_last
);
    import pftba_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LAUNCH,
        ST_WAIT,
        ST_DIV,
        ST_OUT_LAT,
        ST_OUT_PRE
    } state_t;

    state_t      state_reg;
    logic [31:0] window_reg;
    logic [31:0] minev_reg;
    tok_t        inj_reg;
    tok_t        lat_res_reg;
    tok_t        pre_res_reg;
    logic [63:0] pre_key_reg;
    logic [63:0] peak_avg_reg;
    logic [31:0] peak_pre_reg;
    logic [63:0] latest_reg;
    logic        div_start_reg;
    logic        m_valid_reg;
    logic        m_side_reg;
    logic        m_closed_reg;
    logic [63:0] m_key_reg;
    logic [63:0] m_start_reg;
    logic [63:0] m_total_reg;
    logic [31:0] m_count_reg;
    logic        m_visible_reg;
    logic        m_full_reg;
    logic        m_last_reg;

    tok_t        chain [FLOW_SLOTS+1];
    tok_t        tok_out;
    logic        div_busy, div_done;
    logic [63:0] quotient;
    logic        cfg_wr;
    logic [63:0] lat_latest, pre_latest, lat_avg;
    logic [31:0] pre_peak;

    assign chain[0] = inj_reg;
    assign tok_out  = chain[FLOW_SLOTS];

    for (genvar g = 0; g < FLOW_SLOTS; g++) begin : g_cell
        pftba_cell u_cell (
            .aclk               (aclk),
            .aresetn            (aresetn),
            .window_ns          (window_reg),
            .min_events_visible (minev_reg),
            .tok_in             (chain[g]),
            .tok_out            (chain[g+1])
        );
    end

    pftba_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start_reg),
        .dividend (lat_res_reg.ctotal),
        .divisor  (lat_res_reg.ccount),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (quotient)
    );

    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb begin
        case (paddr[2])
            CFG_WINDOW_IDX: prdata = window_reg;
            CFG_MINEV_IDX:  prdata = minev_reg;
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= WINDOW_RESET;
            minev_reg  <= MINEV_RESET;
        end else if (cfg_wr) begin
            case (paddr[2])
                CFG_WINDOW_IDX: window_reg <= pwdata;
                CFG_MINEV_IDX:  minev_reg  <= pwdata;
                default:        window_reg <= window_reg;
            endcase
        end
    end

    always_comb begin
        lat_latest = (lat_res_reg.closed && lat_res_reg.cstart > latest_reg)
                     ? lat_res_reg.cstart : latest_reg;
        lat_avg    = (lat_res_reg.closed && quotient > peak_avg_reg)
                     ? quotient : peak_avg_reg;
        pre_latest = (pre_res_reg.closed && pre_res_reg.cstart > latest_reg)
                     ? pre_res_reg.cstart : latest_reg;
        pre_peak   = (pre_res_reg.closed && pre_res_reg.ccount > peak_pre_reg)
                     ? pre_res_reg.ccount : peak_pre_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            inj_reg.vld   <= 1'b0;
            div_start_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
            peak_avg_reg  <= '0;
            peak_pre_reg  <= '0;
            latest_reg    <= '0;
        end else begin
            div_start_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        inj_reg     <= make_tok(SIDE_LAT, s_running_flow, s_event_time_ns,
                                                s_sample_latency_ns);
                        pre_key_reg <= s_preempted_flow;
                        state_reg   <= ST_LAUNCH;
                    end
                end
                ST_LAUNCH: begin
                    inj_reg   <= make_tok(SIDE_PRE, pre_key_reg, inj_reg.time_ns, '0);
                    state_reg <= ST_WAIT;
                end
                ST_WAIT: begin
                    inj_reg.vld <= 1'b0;
                    if (tok_out.vld && tok_out.side == SIDE_LAT) begin
                        lat_res_reg <= tok_out;
                    end
                    if (tok_out.vld && tok_out.side == SIDE_PRE) begin
                        pre_res_reg   <= tok_out;
                        div_start_reg <= lat_res_reg.closed;
                        state_reg     <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (!div_start_reg && !div_busy) begin
                        peak_avg_reg  <= lat_avg;
                        latest_reg    <= lat_latest;
                        m_valid_reg   <= 1'b1;
                        m_side_reg    <= SIDE_LAT;
                        m_closed_reg  <= lat_res_reg.closed;
                        m_key_reg     <= lat_res_reg.key;
                        m_start_reg   <= lat_res_reg.cstart;
                        m_total_reg   <= lat_res_reg.ctotal;
                        m_count_reg   <= lat_res_reg.ccount;
                        m_visible_reg <= lat_res_reg.visible;
                        m_full_reg    <= !lat_res_reg.done;
                        m_last_reg    <= 1'b0;
                        state_reg     <= ST_OUT_LAT;
                    end
                end
                ST_OUT_LAT: begin
                    if (m_ready) begin
                        peak_pre_reg  <= pre_peak;
                        latest_reg    <= pre_latest;
                        m_side_reg    <= SIDE_PRE;
                        m_closed_reg  <= pre_res_reg.closed;
                        m_key_reg     <= pre_res_reg.key;
                        m_start_reg   <= pre_res_reg.cstart;
                        m_total_reg   <= '0;
                        m_count_reg   <= pre_res_reg.ccount;
                        m_visible_reg <= pre_res_reg.visible;
                        m_full_reg    <= !pre_res_reg.done;
                        m_last_reg    <= 1'b1;
                        state_reg     <= ST_OUT_PRE;
                    end
                end
                ST_OUT_PRE: begin
                    if (m_ready) begin
                        m_valid_reg <= 1'b0;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready               = (state_reg == ST_IDLE);
    assign m_valid               = m_valid_reg;
    assign m_side                = m_side_reg;
    assign m_bin_closed          = m_closed_reg;
    assign m_flow_key            = m_key_reg;
    assign m_closed_start_ns     = m_start_reg;
    assign m_closed_total_ns     = m_total_reg;
    assign m_closed_count        = m_count_reg;
    assign m_visible             = m_visible_reg;
    assign m_table_full          = m_full_reg;
    assign m_peak_avg_latency_ns = peak_avg_reg;
    assign m_peak_preemptions    = peak_pre_reg;
    assign m_latest_closed_ns    = latest_reg;
    assign m_last                = m_last_reg;

    `PFTBA_ASSERT_NEXT(a_accept_no_result, aclk, aresetn, s_valid && s_ready, !m_valid)
    `PFTBA_ASSERT_NEXT(a_second_beat, aclk, aresetn, m_valid && m_ready && !m_last,
                       m_valid && m_last)
    `PFTBA_ASSERT_SAME(a_chain_out_wait, aclk, aresetn, tok_out.vld, state_reg == ST_WAIT)
    `PFTBA_ASSERT_SAME(a_div_in_div, aclk, aresetn, div_busy || div_done,
                       state_reg == ST_DIV)

endmodule

// ===== bench/testbench.sv =====
// self-checking testbench for the per-flow time-bin aggregator
`timescale 1ns / 1ps
module testbench;
    import pftba_pkg::*;

    localparam int SLOTS = 64;

    typedef struct packed {
        logic        side;
        logic        closed;
        logic [63:0] key;
        logic [63:0] cstart;
        logic [63:0] ctotal;
        logic [31:0] ccount;
        logic        visible;
        logic        full;
        logic [63:0] pk_avg;
        logic [31:0] pk_pre;
        logic [63:0] pk_latest;
        logic        last;
    } bin_report_t;

    typedef struct {
        logic [63:0] t_ns;
        logic [63:0] run_id;
        logic [63:0] pre_id;
        logic [63:0] lat;
        bit          known;
        logic        closed;
        logic [63:0] cstart;
        logic [63:0] ctotal;
        logic [31:0] ccount;
    } event_row_t;

    logic        aclk;
    logic        aresetn;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid;
    logic        s_ready;
    logic [63:0] s_event_time_ns;
    logic [63:0] s_running_flow;
    logic [63:0] s_preempted_flow;
    logic [63:0] s_sample_latency_ns;
    logic        m_valid;
    logic        m_ready;
    logic        m_side;
    logic        m_bin_closed;
    logic [63:0] m_flow_key;
    logic [63:0] m_closed_start_ns;
    logic [63:0] m_closed_total_ns;
    logic [31:0] m_closed_count;
    logic        m_visible;
    logic        m_table_full;
    logic [63:0] m_peak_avg_latency_ns;
    logic [31:0] m_peak_preemptions;
    logic [63:0] m_latest_closed_ns;
    logic        m_last;

    per_flow_time_bin_aggregator #(.FLOW_SLOTS(SLOTS)) u_dut (.*);

    // flow table shadow
    logic [31:0] win_ns;
    logic [31:0] min_events;
    logic [63:0] ids [SLOTS];
    bit          used [SLOTS];
    int          n_alloc;
    logic [63:0] lb_start [SLOTS];
    logic [63:0] lb_sum [SLOTS];
    logic [31:0] lb_cnt [SLOTS];
    bit          lb_open [SLOTS];
    logic [63:0] pb_start [SLOTS];
    logic [31:0] pb_cnt [SLOTS];
    bit          pb_open [SLOTS];
    logic [31:0] events [SLOTS];
    logic [63:0] peak_avg;
    logic [31:0] peak_pre;
    logic [63:0] latest_closed;

    bin_report_t pending_reports[$];
    logic [63:0] id_pool[$];
    logic [63:0] now_ns;
    int          errors;
    int          beats_checked;
    int          events_sent;
    int          full_seen;
    bit          hold_req;
    bit          calm;

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #30_000_000;
        $display("timeout with %0d beats pending", pending_reports.size());
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        errors++;
        $display("mismatch %s: got %0h expected %0h (beat %0d)", what, got, want, beats_checked);
    endtask

    function automatic int flow_slot(input logic [63:0] id);
        int s;
        for (s = 0; s < SLOTS; s++)
            if (used[s] && ids[s] == id) return s;
        if (n_alloc >= SLOTS) return -1;
        s = n_alloc;
        used[s] = 1;
        ids[s] = id;
        events[s] = '0;
        lb_open[s] = 0;
        pb_open[s] = 0;
        n_alloc++;
        return s;
    endfunction

    function automatic void predict_event(input logic [63:0] t, input logic [63:0] run_id,
                                          input logic [63:0] pre_id, input logic [63:0] lat);
        bin_report_t r;
        int s;
        logic [63:0] sum2;
        logic [63:0] avg;
        r = '0;
        r.side = SIDE_LAT;
        r.key = run_id;
        s = flow_slot(run_id);
        if (s < 0) begin
            r.full = 1'b1;
        end else begin
            if (lb_open[s] && (t - lb_start[s]) < {32'd0, win_ns}) begin
                sum2 = lb_sum[s] + lat;
                lb_sum[s] = (sum2 < lat) ? '1 : sum2;
                if (lb_cnt[s] != '1) lb_cnt[s]++;
            end else begin
                if (lb_open[s]) begin
                    avg = lb_sum[s] / ((lb_cnt[s] != 0) ? {32'd0, lb_cnt[s]} : 64'd1);
                    r.closed = 1'b1;
                    r.cstart = lb_start[s];
                    r.ctotal = lb_sum[s];
                    r.ccount = lb_cnt[s];
                    if (lb_start[s] > latest_closed) latest_closed = lb_start[s];
                    if (avg > peak_avg) peak_avg = avg;
                end
                lb_open[s] = 1;
                lb_start[s] = t;
                lb_sum[s] = lat;
                lb_cnt[s] = 32'd1;
            end
            if (events[s] != '1) events[s]++;
            r.visible = events[s] >= min_events;
        end
        r.pk_avg = peak_avg;
        r.pk_pre = peak_pre;
        r.pk_latest = latest_closed;
        pending_reports.push_back(r);

        r = '0;
        r.side = SIDE_PRE;
        r.key = pre_id;
        r.last = 1'b1;
        s = flow_slot(pre_id);
        if (s < 0) begin
            r.full = 1'b1;
        end else begin
            if (pb_open[s] && (t - pb_start[s]) < {32'd0, win_ns}) begin
                if (pb_cnt[s] != '1) pb_cnt[s]++;
            end else begin
                if (pb_open[s]) begin
                    r.closed = 1'b1;
                    r.cstart = pb_start[s];
                    r.ccount = pb_cnt[s];
                    if (pb_start[s] > latest_closed) latest_closed = pb_start[s];
                    if (pb_cnt[s] > peak_pre) peak_pre = pb_cnt[s];
                end
                pb_open[s] = 1;
                pb_start[s] = t;
                pb_cnt[s] = 32'd1;
            end
            r.visible = events[s] >= min_events;
        end
        r.pk_avg = peak_avg;
        r.pk_pre = peak_pre;
        r.pk_latest = latest_closed;
        pending_reports.push_back(r);
    endfunction

    // result side: random stalls, one long hold on request
    initial begin
        int stall;
        bin_report_t e;
        stall = 0;
        m_ready = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (m_valid && m_ready) begin
                if (pending_reports.size() == 0) begin
                    report("unexpected beat key", m_flow_key, 64'd0);
                end else begin
                    e = pending_reports.pop_front();
                    if (m_side !== e.side) report("side", m_side, e.side);
                    if (m_bin_closed !== e.closed) report("bin_closed", m_bin_closed, e.closed);
                    if (m_flow_key !== e.key) report("flow_key", m_flow_key, e.key);
                    if (m_closed_start_ns !== e.cstart)
                        report("closed_start_ns", m_closed_start_ns, e.cstart);
                    if (m_closed_total_ns !== e.ctotal)
                        report("closed_total_ns", m_closed_total_ns, e.ctotal);
                    if (m_closed_count !== e.ccount)
                        report("closed_count", m_closed_count, e.ccount);
                    if (m_visible !== e.visible) report("visible", m_visible, e.visible);
                    if (m_table_full !== e.full) report("table_full", m_table_full, e.full);
                    if (m_peak_avg_latency_ns !== e.pk_avg)
                        report("peak_avg_latency_ns", m_peak_avg_latency_ns, e.pk_avg);
                    if (m_peak_preemptions !== e.pk_pre)
                        report("peak_preemptions", m_peak_preemptions, e.pk_pre);
                    if (m_latest_closed_ns !== e.pk_latest)
                        report("latest_closed_ns", m_latest_closed_ns, e.pk_latest);
                    if (m_last !== e.last) report("last", m_last, e.last);
                    if (e.full) full_seen++;
                end
                beats_checked++;
            end
            if (hold_req) begin
                hold_req = 0;
                stall = 300;
            end
            if (stall > 0) begin
                stall--;
                m_ready <= 1'b0;
            end else if (calm || $urandom_range(0, 99) < 70) begin
                m_ready <= 1'b1;
            end else begin
                stall = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(20, 60);
                m_ready <= 1'b0;
            end
            @(posedge aclk);
        end
    end

    task automatic apb_write(input logic idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == CFG_WINDOW_IDX) win_ns = value;
        else min_events = value;
    endtask

    // stop offering and wait until every predicted beat has come back
    task automatic drain;
        s_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic set_config(input logic [31:0] w, input logic [31:0] m);
        drain();
        apb_write(CFG_WINDOW_IDX, w);
        apb_write(CFG_MINEV_IDX, m);
    endtask

    // called at a rising edge; returns after the beat is accepted and any random idle gap
    task automatic send_event(input logic [63:0] t, input logic [63:0] run_id,
                              input logic [63:0] pre_id, input logic [63:0] lat);
        int gap;
        s_valid             <= 1'b1;
        s_event_time_ns     <= t;
        s_running_flow      <= run_id;
        s_preempted_flow    <= pre_id;
        s_sample_latency_ns <= lat;
        do @(posedge aclk); while (!s_ready);
        predict_event(t, run_id, pre_id, lat);
        events_sent++;
        if (calm) gap = 0;
        else if ($urandom_range(0, 99) < 60) gap = 0;
        else if ($urandom_range(0, 99) < 85) gap = $urandom_range(1, 3);
        else gap = $urandom_range(20, 60);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    function automatic logic [63:0] pick_id(input int new_pct);
        logic [63:0] id;
        if ($urandom_range(0, 99) < new_pct) begin
            id = {$urandom, $urandom};
            id_pool.push_back(id);
            return id;
        end
        if ($urandom_range(0, 99) < 80) return id_pool[$urandom_range(0, 7)];
        return id_pool[$urandom_range(0, id_pool.size() - 1)];
    endfunction

    task automatic random_events(input int n, input int new_pct, input bit with_hold);
        logic [63:0] lat;
        logic [63:0] run_id;
        int k;
        int r;
        for (k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < 80) now_ns = now_ns + $urandom_range(0, win_ns / 32);
            else if (r < 90) now_ns = {$urandom, $urandom};
            else now_ns = 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, win_ns / 16);
            r = $urandom_range(0, 99);
            if (r < 90) lat = $urandom_range(0, 100000);
            else if (r < 95) lat = {$urandom, $urandom};
            else lat = '1;
            run_id = pick_id(new_pct);
            if (with_hold && k == n / 3) hold_req = 1;
            if (with_hold && k == 2 * n / 3) drain();
            send_event(now_ns, run_id, ($urandom_range(0, 9) == 0) ? run_id : pick_id(new_pct),
                       lat);
        end
    endtask

    initial begin
        event_row_t rows[$];
        event_row_t row;
        bin_report_t p;
        logic [63:0] id;
        int k;
        int j;
        bit dup;
        errors = 0;
        beats_checked = 0;
        events_sent = 0;
        full_seen = 0;
        hold_req = 0;
        calm = 0;
        aresetn = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        s_valid = 1'b0;
        s_event_time_ns = '0;
        s_running_flow = '0;
        s_preempted_flow = '0;
        s_sample_latency_ns = '0;
        win_ns = WINDOW_RESET;
        min_events = MINEV_RESET;
        n_alloc = 0;
        peak_avg = '0;
        peak_pre = '0;
        latest_closed = '0;
        now_ns = '0;
        for (k = 0; k < SLOTS; k++) begin
            used[k] = 0;
            lb_open[k] = 0;
            pb_open[k] = 0;
            events[k] = '0;
        end

        rows.push_back('{64'd0, 64'd1, 64'd2, 64'd100, 1, 0, 0, 0, 0});
        rows.push_back('{64'd10, 64'd1, 64'd2, 64'd300, 1, 0, 0, 0, 0});
        rows.push_back('{64'd200000000, 64'd1, 64'd2, 64'd50, 1, 1, 64'd0, 64'd400, 32'd2});
        rows.push_back('{64'hFFFF_FFFF_FFFF_FFF0, '1, 64'd0, '1, 1, 0, 0, 0, 0});
        rows.push_back('{64'h10, '1, 64'd0, 64'd5, 1, 0, 0, 0, 0});
        rows.push_back('{64'h20, '1, 64'd0, 64'd0, 0, 0, 0, 0, 0});
        rows.push_back('{64'h20 + 64'd200000000, '1, 64'd0, 64'd7, 1, 1,
                         64'hFFFF_FFFF_FFFF_FFF0, '1, 32'd3});
        rows.push_back('{64'd5, 64'd3, 64'd3, 64'd9, 1, 0, 0, 0, 0});
        rows.push_back('{64'd4, 64'd3, 64'd3, 64'd1, 1, 1, 64'd5, 64'd9, 32'd1});
        rows.push_back('{64'd1000, 64'd2, 64'd1, 64'h8000_0000_0000_0000, 1, 0, 0, 0, 0});
        rows.push_back('{64'd200000999, 64'd2, 64'd1, 64'd1, 0, 0, 0, 0, 0});
        rows.push_back('{64'd300000000, 64'd1, 64'd2, 64'hAAAA_AAAA_AAAA_AAAA, 0, 0, 0, 0, 0});

        id_pool.push_back(64'd1);
        id_pool.push_back(64'd2);
        id_pool.push_back(64'd3);
        while (id_pool.size() < 59) begin
            id = {$urandom, $urandom};
            dup = (id == 0) || (id == '1);
            for (j = 0; j < id_pool.size(); j++)
                if (id_pool[j] == id) dup = 1;
            if (!dup) id_pool.push_back(id);
        end

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed rows at reset register values
        foreach (rows[k]) begin
            row = rows[k];
            send_event(row.t_ns, row.run_id, row.pre_id, row.lat);
            if (row.known) begin
                p = pending_reports[pending_reports.size() - 2];
                if (p.closed !== row.closed) report("row bin_closed", p.closed, row.closed);
                if (p.cstart !== row.cstart) report("row closed_start", p.cstart, row.cstart);
                if (p.ctotal !== row.ctotal) report("row closed_total", p.ctotal, row.ctotal);
                if (p.ccount !== row.ccount) report("row closed_count", p.ccount, row.ccount);
            end
        end

        set_config(32'd1000, 32'd0);
        random_events(260, 0, 1);
        set_config(32'd0, 32'd5);
        random_events(150, 0, 0);
        set_config('1, '1);
        calm = 1;
        random_events(150, 0, 0);
        calm = 0;
        set_config(32'd1, 32'd20);
        random_events(150, 0, 0);
        set_config(32'd50000, 32'd3);
        random_events(380, 15, 0);

        drain();
        repeat (150) @(posedge aclk);
        $display("%0d events sent, %0d result beats checked, %0d dropped on a full table",
                 events_sent, beats_checked, full_seen);
        $display("windows 0, 1, 1000, 50000, 200000000 and 2^32-1; %0d flows allocated",
                 n_alloc);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches", errors);
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
